/* hdl/owus_pkg.sv */
// Shared types, codes and constants for the 1-Wire over UART slot sequencer.
// It depends on nothing. The core, the result queue and the top level import it.
`default_nettype none

package owus_pkg;

   localparam int STORE_DEPTH = 11;
   localparam int RSP_DEPTH   = 4;

   localparam logic [7:0] RESET_BYTE    = 8'hF0;
   localparam logic [7:0] SLOT_ONE      = 8'hFF;
   localparam logic [7:0] SLOT_ZERO     = 8'h00;
   localparam logic [7:0] ROM_READ      = 8'h33;
   localparam logic [7:0] ROM_MATCH     = 8'h55;
   localparam logic [7:0] ROM_SKIP      = 8'hCC;
   localparam logic [7:0] FN_WRITE_PAD  = 8'h4E;
   localparam logic [7:0] FN_READ_PAD   = 8'hBE;
   localparam logic [4:0] PAD_RX_BASE   = 5'd8;
   localparam logic [3:0] PAD_TX_BASE   = 4'd8;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_LOAD  = 2'd1,
      OP_ECHO  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_SLOT  = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_RESET   = 3'd1,
      PH_ROM_CMD = 3'd2,
      PH_ROM_TX  = 3'd3,
      PH_ROM_RX  = 3'd4,
      PH_FN_CMD  = 3'd5,
      PH_FN_TX   = 3'd6,
      PH_FN_RX   = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] echo_byte;
      logic [7:0] tx_value;
      logic [3:0] tx_index;
      logic [7:0] func_cmd;
      logic [7:0] rom_cmd;
      op_type     op;
   } req_item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] slot_byte;
      logic       high_speed;
      logic [4:0] rx_index;
      logic [7:0] rx_value;
      logic       last;
   } result_type;

   // Up to two results leave the core per item; count says how many are valid.
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

   // Number of bytes in each transfer segment.
   function automatic logic [3:0] seg_len(phase_type ph);
      logic [3:0] len;
      unique case (ph)
         PH_ROM_TX: len = 4'd8;
         PH_ROM_RX: len = 4'd8;
         PH_FN_TX:  len = 4'd3;
         PH_FN_RX:  len = 4'd9;
         default:   len = 4'd1;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* hdl/owus_core.sv */
// Input register, transaction state and the per-item logic of the sequencer.
// It uses owus_pkg and hands at most two results per item to the result queue.
`default_nettype none

module owus_core import owus_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire req_item_type in_item,
   output logic              in_ready,
   input  wire logic         room,
   output push_type          push
);

   logic         item_valid_ff, item_valid_in;
   req_item_type item_ff;
   logic         fire;

   phase_type  phase_ff, phase_in;
   logic [7:0] rom_ff, rom_in;
   logic [7:0] func_ff, func_in;
   logic [2:0] bit_ff, bit_in;
   logic [3:0] byte_ff, byte_in;
   logic [7:0] shift_ff, shift_in;

   logic [7:0] store_ff [STORE_DEPTH];
   logic       store_we;

   logic       rx, wrap, echo_one, have_data, have_final, is_start, seg_done;
   logic [3:0] byte_inc, store_idx;
   logic [7:0] shift_nx, src_byte;
   kind_type   final_kind;
   result_type data_r, final_r;

   assign fire          = item_valid_ff && room;
   assign in_ready      = !item_valid_ff || fire;
   assign item_valid_in = in_valid ? 1'b1 : (fire ? 1'b0 : item_valid_ff);

   assign rx       = (phase_ff == PH_ROM_RX) || (phase_ff == PH_FN_RX);
   assign wrap     = (bit_ff == 3'd7);
   assign echo_one = (item_ff.echo_byte == SLOT_ONE);
   assign shift_nx = shift_ff | ((rx && echo_one) ? (8'd1 << bit_ff) : 8'd0);
   assign byte_inc = byte_ff + 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      rom_in     = rom_ff;
      func_in    = func_ff;
      bit_in     = bit_ff;
      byte_in    = byte_ff;
      shift_in   = shift_ff;
      store_we   = 1'b0;
      have_data  = 1'b0;
      have_final = 1'b0;
      is_start   = 1'b0;
      seg_done   = 1'b0;
      final_kind = KIND_SLOT;
      if (fire) begin
         unique case (item_ff.op)
            OP_START: begin
               rom_in     = item_ff.rom_cmd;
               func_in    = item_ff.func_cmd;
               bit_in     = 3'd0;
               byte_in    = 4'd0;
               shift_in   = 8'd0;
               phase_in   = PH_RESET;
               have_final = 1'b1;
               is_start   = 1'b1;
            end
            OP_LOAD: begin
               store_we = (item_ff.tx_index < 4'(STORE_DEPTH));
            end
            OP_ECHO: begin
               if (phase_ff == PH_RESET) begin
                  have_final = 1'b1;
                  if (item_ff.echo_byte == RESET_BYTE) begin
                     // No presence pulse pulled the line: report and give up.
                     phase_in   = PH_IDLE;
                     final_kind = KIND_ERROR;
                  end else begin
                     phase_in = PH_ROM_CMD;
                     bit_in   = 3'd0;
                     byte_in  = 4'd0;
                     shift_in = 8'd0;
                  end
               end else if (phase_ff != PH_IDLE) begin
                  have_final = 1'b1;
                  bit_in     = bit_ff + 3'd1;
                  shift_in   = shift_nx;
                  if (wrap) begin
                     if (rx) begin
                        have_data = 1'b1;
                        shift_in  = 8'd0;
                     end
                     byte_in = byte_inc;
                     if (byte_inc >= seg_len(phase_ff)) begin
                        byte_in = 4'd0;
                        priority case (phase_ff)
                           PH_ROM_CMD: begin
                              if (rom_ff == ROM_MATCH)     phase_in = PH_ROM_TX;
                              else if (rom_ff == ROM_READ) phase_in = PH_ROM_RX;
                              else                         phase_in = PH_FN_CMD;
                           end
                           PH_ROM_TX, PH_ROM_RX: phase_in = PH_FN_CMD;
                           PH_FN_CMD: begin
                              if (func_ff == FN_WRITE_PAD)     phase_in = PH_FN_TX;
                              else if (func_ff == FN_READ_PAD) phase_in = PH_FN_RX;
                              else                             seg_done = 1'b1;
                           end
                           default: seg_done = 1'b1;
                        endcase
                     end
                  end
                  if (seg_done) begin
                     phase_in   = PH_IDLE;
                     bit_in     = 3'd0;
                     byte_in    = 4'd0;
                     shift_in   = 8'd0;
                     final_kind = KIND_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The next slot is taken from the state as it stands after this item.
   always_comb begin
      store_idx = 4'd0;
      src_byte  = SLOT_ONE;
      unique case (phase_in)
         PH_ROM_CMD: src_byte = rom_in;
         PH_FN_CMD:  src_byte = func_in;
         PH_ROM_TX: begin
            store_idx = byte_in;
            src_byte  = store_ff[store_idx];
         end
         PH_FN_TX: begin
            store_idx = PAD_TX_BASE + byte_in;
            src_byte  = store_ff[store_idx];
         end
         default: src_byte = SLOT_ONE;
      endcase
   end

   always_comb begin
      data_r            = '0;
      data_r.kind       = KIND_DATA;
      data_r.rx_index   = {1'b0, byte_ff} + ((phase_ff == PH_FN_RX) ? PAD_RX_BASE : 5'd0);
      data_r.rx_value   = shift_nx;
      final_r           = '0;
      final_r.kind      = final_kind;
      final_r.last      = 1'b1;
      if (final_kind == KIND_SLOT) begin
         final_r.high_speed = !is_start;
         if (is_start) final_r.slot_byte = RESET_BYTE;
         else          final_r.slot_byte = src_byte[bit_in] ? SLOT_ONE : SLOT_ZERO;
      end
      push.count = {1'b0, have_final} + {1'b0, have_data};
      push.r0    = have_data ? data_r : final_r;
      push.r1    = final_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         rom_ff        <= 8'd0;
         func_ff       <= 8'd0;
         bit_ff        <= 3'd0;
         byte_ff       <= 4'd0;
         shift_ff      <= 8'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         rom_ff        <= rom_in;
         func_ff       <= func_in;
         bit_ff        <= bit_in;
         byte_ff       <= byte_in;
         shift_ff      <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) item_ff <= in_item;
   end

   always_ff @(posedge clock) begin
      if (store_we) store_ff[item_ff.tx_index] <= item_ff.tx_value;
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (bit_ff == 3'd0 && byte_ff == 4'd0 && shift_ff == 8'd0))
      else $error("idle with counters or shift byte not cleared");

   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      byte_ff < seg_len(phase_ff))
      else $error("byte count beyond the current segment");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (fire && item_ff.op == OP_START) |-> (push.count == 2'd1) ##1 (phase_ff == PH_RESET))
      else $error("start did not give one reset slot and enter the reset phase");

   a_no_push_without_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("results pushed while the result queue is short of room");

endmodule

`default_nettype wire

/* hdl/owus_rsp_fifo.sv */
// Result queue of the sequencer: takes up to two results a cycle, gives one while the consumer is ready.
// It uses the result and push types of owus_pkg.
`default_nettype none

module owus_rsp_fifo import owus_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_data
);

   localparam int PW = $clog2(RSP_DEPTH);

   result_type      mem_ff [RSP_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in, wp_next;
   logic [PW:0]     count_ff, count_in;
   logic            pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   // Room is judged before this cycle's pop so it never depends on the far side.
   assign room      = (count_ff <= (PW+1)'(RSP_DEPTH - 2));
   assign wp_next   = wp_ff + PW'(1);
   assign wp_in     = wp_ff + PW'(push.count);
   assign rp_in     = pop ? rp_ff + PW'(1) : rp_ff;
   assign count_in  = count_ff + (PW+1)'(push.count) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wp_ff]   <= push.r0;
      if (push.count == 2'd2) mem_ff[wp_next] <= push.r1;
   end

endmodule

`default_nettype wire

/* hdl/onewire_uart_slot_sequencer.sv */
// A request word is registered, then decoded; its results go into the four-entry result
// queue, which offers them. One request word is taken per cycle while results drain as fast
// and the queue has room; a word that yields two results (a finished read byte and the next
// slot) still leaves one result at a time, so the sustained rate is one result a cycle.
// Reset (synchronous, active high) returns the sequence to idle and clears counters and
// queue; the eleven-byte transmit store keeps whatever it held and is defined only once loaded.
`default_nettype none

module onewire_uart_slot_sequencer import owus_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: rom_cmd[7:0], func_cmd[15:8], tx_index[19:16], tx_value[27:20],
   //        echo_byte[35:28], zero[39:36].
   input  wire logic [39:0] req_tdata,
   // tuser: op[1:0] (start, load transmit byte, echo arrived).
   input  wire logic [1:0]  req_tuser,
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: slot_byte[7:0], high_speed[8], rx_index[13:9], rx_value[21:14], zero[23:22].
   output logic [23:0]      rsp_tdata,
   // tuser: kind[1:0] (slot byte, received byte, done, no presence error).
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   req_item_type in_item;
   push_type     push;
   logic         room;
   result_type   out_r;

   // Unpack the request word; the op code rides in tuser.
   always_comb begin
      in_item.op        = op_type'(req_tuser);
      in_item.rom_cmd   = req_tdata[7:0];
      in_item.func_cmd  = req_tdata[15:8];
      in_item.tx_index  = req_tdata[19:16];
      in_item.tx_value  = req_tdata[27:20];
      in_item.echo_byte = req_tdata[35:28];
   end

   // The core holds the request register and the whole transaction state.
   // Every slot byte it asks for must come back as an echo word before it moves on.
   owus_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_item  (in_item),
      .in_ready (req_tready),
      .room     (room),
      .push     (push)
   );

   // The queue decouples the two sides so a stalled consumer does not stop decode
   // until it is nearly full.
   owus_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_r)
   );

   assign rsp_tdata = {2'b00, out_r.rx_value, out_r.rx_index, out_r.high_speed,
                       out_r.slot_byte};
   assign rsp_tuser = out_r.kind;
   assign rsp_tlast = out_r.last;

endmodule

`default_nettype wire

/* tb/sv/slot_check_pkg.sv */
// Scoreboard for the 1-Wire over UART slot sequencer: a cycle-free predictor of its result words
// and the in-order comparison against what the block delivers. Depends on owus_pkg.
package slot_check_pkg;
   import owus_pkg::*;

   class slot_word_checker;
      phase_type  phase;
      logic [7:0] rom_cmd;
      logic [7:0] fn_cmd;
      logic [2:0] bit_cnt;
      logic [3:0] byte_cnt;
      logic [7:0] rx_shift;
      logic [7:0] tx_bytes [STORE_DEPTH];
      result_type pending_words [$];
      int         errors;

      function new();
         phase    = PH_IDLE;
         rom_cmd  = '0;
         fn_cmd   = '0;
         bit_cnt  = '0;
         byte_cnt = '0;
         rx_shift = '0;
         errors   = 0;
         foreach (tx_bytes[i]) tx_bytes[i] = '0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function int segment_bytes(phase_type ph);
         case (ph)
            PH_ROM_TX, PH_ROM_RX: return 8;
            PH_FN_TX:             return 3;
            PH_FN_RX:             return 9;
            default:              return 1;
         endcase
      endfunction

      // Byte put on the line for the current bit; read slots always send all ones.
      function logic [7:0] slot_for_bit();
         logic [7:0] src;
         case (phase)
            PH_ROM_CMD: src = rom_cmd;
            PH_FN_CMD:  src = fn_cmd;
            PH_ROM_TX:  src = tx_bytes[byte_cnt];
            PH_FN_TX:   src = tx_bytes[PAD_TX_BASE + byte_cnt];
            default:    return SLOT_ONE;
         endcase
         return src[bit_cnt] ? SLOT_ONE : SLOT_ZERO;
      endfunction

      function void add_word(kind_type k, logic [7:0] slot, logic hs, logic [4:0] idx,
                             logic [7:0] val);
         result_type w;
         w.kind       = k;
         w.slot_byte  = slot;
         w.high_speed = hs;
         w.rx_index   = idx;
         w.rx_value   = val;
         w.last       = 1'b0;
         pending_words.push_back(w);
      endfunction

      // Advances the sequence by one accepted request word and queues what it yields.
      function void note_request(logic [1:0] op, logic [39:0] data);
         int         prior_size;
         bit         rx;
         bit         finished;
         logic [4:0] base;
         prior_size = pending_words.size();
         finished   = 1'b0;
         if (op == OP_START) begin
            rom_cmd  = data[7:0];
            fn_cmd   = data[15:8];
            bit_cnt  = '0;
            byte_cnt = '0;
            rx_shift = '0;
            phase    = PH_RESET;
            add_word(KIND_SLOT, RESET_BYTE, 1'b0, '0, '0);
         end else if (op == OP_LOAD) begin
            if (data[19:16] < STORE_DEPTH) tx_bytes[data[19:16]] = data[27:20];
         end else if (op == OP_ECHO && phase != PH_IDLE) begin
            if (phase == PH_RESET) begin
               if (data[35:28] == RESET_BYTE) begin
                  phase = PH_IDLE;
                  add_word(KIND_ERROR, '0, 1'b0, '0, '0);
               end else begin
                  phase    = PH_ROM_CMD;
                  bit_cnt  = '0;
                  byte_cnt = '0;
                  rx_shift = '0;
                  add_word(KIND_SLOT, slot_for_bit(), 1'b1, '0, '0);
               end
            end else begin
               rx = (phase == PH_ROM_RX) || (phase == PH_FN_RX);
               if (rx && data[35:28] == SLOT_ONE) rx_shift[bit_cnt] = 1'b1;
               bit_cnt = bit_cnt + 3'd1;
               if (bit_cnt == 3'd0) begin
                  if (rx) begin
                     base = (phase == PH_FN_RX) ? PAD_RX_BASE : 5'd0;
                     add_word(KIND_DATA, '0, 1'b0, base + 5'(byte_cnt), rx_shift);
                     rx_shift = '0;
                  end
                  byte_cnt = byte_cnt + 4'd1;
                  if (byte_cnt >= segment_bytes(phase)) begin
                     byte_cnt = '0;
                     case (phase)
                        PH_ROM_CMD: begin
                           if (rom_cmd == ROM_MATCH) phase = PH_ROM_TX;
                           else if (rom_cmd == ROM_READ) phase = PH_ROM_RX;
                           else phase = PH_FN_CMD;
                        end
                        PH_ROM_TX, PH_ROM_RX: phase = PH_FN_CMD;
                        PH_FN_CMD: begin
                           if (fn_cmd == FN_WRITE_PAD) phase = PH_FN_TX;
                           else if (fn_cmd == FN_READ_PAD) phase = PH_FN_RX;
                           else finished = 1'b1;
                        end
                        default: finished = 1'b1;
                     endcase
                  end
               end
               if (finished) begin
                  phase    = PH_IDLE;
                  bit_cnt  = '0;
                  byte_cnt = '0;
                  rx_shift = '0;
                  add_word(KIND_DONE, '0, 1'b0, '0, '0);
               end else begin
                  add_word(KIND_SLOT, slot_for_bit(), 1'b1, '0, '0);
               end
            end
         end
         if (pending_words.size() > prior_size)
            pending_words[pending_words.size() - 1].last = 1'b1;
      endfunction

      task check_result(logic [1:0] kind, logic [23:0] data, logic last);
         result_type w;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d data %h", kind, data));
            return;
         end
         w = pending_words.pop_front();
         if (kind != w.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, w.kind));
         if (data[7:0] != w.slot_byte)
            report_mismatch($sformatf("slot byte %h, expected %h", data[7:0], w.slot_byte));
         if (data[8] != w.high_speed)
            report_mismatch($sformatf("high speed %b, expected %b", data[8], w.high_speed));
         if (data[13:9] != w.rx_index)
            report_mismatch($sformatf("rx index %0d, expected %0d", data[13:9], w.rx_index));
         if (data[21:14] != w.rx_value)
            report_mismatch($sformatf("rx value %h, expected %h", data[21:14], w.rx_value));
         if (data[23:22] != 2'b00)
            report_mismatch($sformatf("pad bits %b, expected zero", data[23:22]));
         if (last != w.last)
            report_mismatch($sformatf("last %b, expected %b", last, w.last));
      endtask
   endclass

endpackage

/* tb/sv/testbench.sv */
// Top of the slot sequencer testbench: clock, reset, request and result drivers, and the
// directed and random transaction stimulus. Depends on owus_pkg and slot_check_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import owus_pkg::*;
   import slot_check_pkg::*;

   // Op code the block has no meaning for; it must be swallowed without a result.
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         LONG_HOLD   = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_cycles   = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   slot_word_checker tracker = new();

   onewire_uart_slot_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // All handshakes are observed at the rising edge, where every driven input has been
   // stable since the previous falling edge. A request word is noted before any result of
   // the same edge is checked, although the block's latency keeps the two apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog: a run that goes on past the cycle limit ends as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL onewire_uart_slot_sequencer");
         $finish;
      end
   end

   // Result side back-pressure. A long hold, once requested, is counted down here and
   // takes priority over the random stalls.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Background for a request word: every field but the zero bits random, so the fields an op does not use
   // still toggle; the caller then overwrites the fields that matter.
   function automatic logic [39:0] random_fields();
      return {4'h0, 4'($urandom_range(15)), 32'($urandom)};
   endfunction

   // Offers one word, with random idle cycles in front, and returns at the falling edge
   // after it was taken. Called only at a falling edge.
   task automatic send_word(logic [1:0] op, logic [39:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_start(logic [7:0] rom, logic [7:0] fn);
      logic [39:0] data;
      data       = random_fields();
      data[7:0]  = rom;
      data[15:8] = fn;
      items_sent++;
      send_word(OP_START, data);
   endtask

   task automatic send_load(logic [3:0] idx, logic [7:0] val);
      logic [39:0] data;
      data        = random_fields();
      data[19:16] = idx;
      data[27:20] = val;
      if (idx < STORE_DEPTH) items_sent++;
      send_word(OP_LOAD, data);
   endtask

   task automatic send_echo(logic [7:0] echo);
      logic [39:0] data;
      data        = random_fields();
      data[35:28] = echo;
      items_sent++;
      send_word(OP_ECHO, data);
   endtask

   // Echo seen on the line after a slot. Read slots care only whether it is all ones, so
   // that value and all zeros dominate; the rest exercises arbitrary line noise.
   function automatic logic [7:0] pick_echo();
      int r;
      r = $urandom_range(9);
      if (r < 4) return SLOT_ONE;
      if (r < 7) return SLOT_ZERO;
      return 8'($urandom);
   endfunction

   // Noise that may fall inside a running transaction: it must not be an echo, which
   // would consume a slot, but a load may rewrite a byte that is still to be sent.
   task automatic send_quiet_noise();
      if ($urandom_range(1) == 0) send_word(OP_UNUSED, random_fields());
      else send_load(4'($urandom_range(15)), 8'($urandom));
   endtask

   // Noise between transactions; an echo here usually meets an idle sequencer.
   task automatic send_noise();
      if ($urandom_range(2) == 0) send_echo(pick_echo());
      else send_quiet_noise();
   endtask

   // One transaction with random commands. Most run to completion; some end with no device
   // present and some are cut short, to be dropped by the next start.
   task automatic run_transaction();
      logic [7:0] rom;
      logic [7:0] fn;
      logic [7:0] presence;
      int         slots;
      int         count;
      int         r;
      case ($urandom_range(3))
         0:       rom = ROM_READ;
         1:       rom = ROM_MATCH;
         2:       rom = ROM_SKIP;
         default: rom = 8'($urandom);
      endcase
      case ($urandom_range(2))
         0:       fn = FN_WRITE_PAD;
         1:       fn = FN_READ_PAD;
         default: fn = 8'($urandom);
      endcase
      // Eight command bits each, plus the data slots of the segments that follow them.
      slots = 16;
      if (rom == ROM_MATCH || rom == ROM_READ) slots += 64;
      if (fn == FN_WRITE_PAD) slots += 24;
      else if (fn == FN_READ_PAD) slots += 72;
      send_start(rom, fn);
      r = $urandom_range(99);
      if (r < 8) begin
         send_echo(RESET_BYTE);
         return;
      end
      do presence = 8'($urandom); while (presence == RESET_BYTE);
      send_echo(presence);
      count = (r < 18) ? $urandom_range(slots - 1) : slots;
      repeat (count) begin
         if ($urandom_range(99) < 4) send_quiet_noise();
         send_echo(pick_echo());
      end
   endtask

   task automatic run_random(int target);
      while (items_sent < target) begin
         run_transaction();
         if ($urandom_range(9) < 3) send_noise();
      end
   endtask

   // The sender holds back until every expected result word has been delivered.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      rsp_idle_pct  = 71;

      // Fill the whole transmit store first, so no transaction ever sends a byte that
      // was never loaded. The first and last entries get the extreme values.
      for (int i = 0; i < STORE_DEPTH; i++) begin
         if (i == 0) send_load(4'(i), 8'h00);
         else if (i == STORE_DEPTH - 1) send_load(4'(i), 8'hFF);
         else send_load(4'(i), 8'($urandom));
      end
      // Words the block must ignore: a load past the store, an echo while idle, op 3.
      send_load(4'hF, 8'hFF);
      send_echo(SLOT_ONE);
      send_word(OP_UNUSED, random_fields());
      // No device answers the reset pulse.
      send_start(ROM_READ, FN_READ_PAD);
      send_echo(RESET_BYTE);
      // A match transaction that is dropped a few slots in by a new start.
      send_start(ROM_MATCH, FN_WRITE_PAD);
      send_echo(8'h00);
      send_echo(SLOT_ONE);
      send_echo(8'h12);
      send_start(ROM_SKIP, FN_READ_PAD);
      send_echo(8'hFE);
      repeat (3) send_echo(SLOT_ONE);

      run_random(600);
      wait_drained();

      send_idle_pct = 71;
      rsp_idle_pct  = 26;
      run_random(1200);
      wait_drained();

      // No idling from here on. The result side first holds off for a long stretch while
      // requests keep coming, so the result queue fills and the request side stalls.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      @(posedge clock);
      hold_cycles = LONG_HOLD;
      @(negedge clock);
      run_random(1775);
      wait_drained();
      repeat (16) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("PASS onewire_uart_slot_sequencer");
      end else begin
         $display("FAIL onewire_uart_slot_sequencer");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/owus_pkg.sv
hdl/owus_core.sv
hdl/owus_rsp_fifo.sv
hdl/onewire_uart_slot_sequencer.sv
tb/sv/slot_check_pkg.sv
tb/sv/testbench.sv
